/* hw/rtl/bte_pkg.sv */
// Shared types and constants for the boundary-terminated byte extractor.
package bte_pkg;

  // Delimiter geometry: fixed CR LF '-' '-' prefix followed by the token.
  localparam int MAX_DELIM_BYTES = 32;
  localparam int PREFIX_BYTES    = 4;
  localparam int TOKEN_CAP       = 28;
  localparam int PAT_BYTES       = PREFIX_BYTES + TOKEN_CAP;
  localparam int PAT_IDX_W       = $clog2(PAT_BYTES);
  localparam int PLEN_W          = PAT_IDX_W + 1;
  localparam int TOK_LEN_W       = 5;
  localparam int TOK_LIM         = (MAX_DELIM_BYTES - PREFIX_BYTES < TOKEN_CAP) ?
                                   (MAX_DELIM_BYTES - PREFIX_BYTES) : TOKEN_CAP;

  localparam logic [7:0] CHAR_CR     = 8'h0D;
  localparam logic [7:0] CHAR_LF     = 8'h0A;
  localparam logic [7:0] CHAR_HYPHEN = 8'h2D;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int WORD3_W    = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TOKEN_LEN   = 3'd0,
    REG_TOKEN_WORD0 = 3'd1,
    REG_TOKEN_WORD1 = 3'd2,
    REG_TOKEN_WORD2 = 3'd3,
    REG_TOKEN_WORD3 = 3'd4
  } cfg_reg_t;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_DATA    = 2'd0,
    KIND_FOUND   = 2'd1,
    KIND_NOMATCH = 2'd2
  } kind_t;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic [PAT_BYTES-1:0][7:0] pat_t;

  typedef struct packed {
    logic       eoi;
    logic [7:0] data;
  } q_item_t;

  typedef struct packed {
    logic    valid;
    q_item_t item;
  } q_head_t;

endpackage

/* hw/rtl/bte_if.sv */
// Valid/ready channel interfaces for body bytes in and results out.
interface bte_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_input;

  modport source (output valid, output in_byte, output end_of_input, input ready);
  modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface bte_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] kind;
  logic       last;

  modport source (output valid, output out_byte, output kind, output last, input ready);
  modport sink   (input valid, input out_byte, input kind, input last, output ready);
endinterface

/* hw/rtl/bte_front.sv */
// Front end: accepts items, tags end of stream and queues them for the back end.
module bte_front (
  input  logic             clk,
  input  logic             rst_n,
  bte_in_if.sink           in_chan,
  output bte_pkg::q_head_t head_o,
  input  logic             pop_i
);
  import bte_pkg::*;

  q_item_t           mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              push;
  logic              pop;
  q_item_t           new_item;

  // Classify: an end-of-stream item carries no byte
  always_comb begin
    new_item.eoi  = in_chan.end_of_input;
    new_item.data = in_chan.end_of_input ? 8'h00 : in_chan.in_byte;
  end

  assign in_chan.ready = (cnt_r != QCNT_W'(QUEUE_DEPTH));
  assign push          = in_chan.valid && in_chan.ready;
  assign pop           = pop_i && (cnt_r != '0);

  assign head_o.valid = (cnt_r != '0);
  assign head_o.item  = mem_r[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= new_item;
    end
  end

endmodule

/* hw/rtl/bte_border.sv */
// Border (failure) table of the delimiter pattern, rebuilt after reset and config writes.
module bte_border (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start_i,
  input  bte_pkg::pat_t                  pat_i,
  input  logic [bte_pkg::PAT_IDX_W-1:0]  rd_addr_i,
  output logic [bte_pkg::PAT_IDX_W-1:0]  rd_data_o,
  output logic                           ready_o
);
  import bte_pkg::*;

  typedef enum logic [1:0] {
    B_BUILD = 2'b01,
    B_DONE  = 2'b10
  } bstate_t;

  bstate_t              state_r, state_nxt;
  logic [PAT_IDX_W-1:0] q_r, q_nxt;
  logic [PAT_IDX_W-1:0] b_r, b_nxt;
  logic [PAT_IDX_W-1:0] nb;
  logic [PAT_IDX_W-1:0] tab_r [PAT_BYTES];
  logic [PAT_IDX_W-1:0] addr;
  logic [PAT_IDX_W-1:0] f_rd;
  logic                 wr_en;
  logic                 bytes_eq;

  // Single read port: builder owns it while building
  assign addr      = (state_r == B_BUILD) ? b_r : rd_addr_i;
  assign f_rd      = (addr <= PAT_IDX_W'(1)) ? '0 : tab_r[addr];
  assign rd_data_o = f_rd;
  assign ready_o   = (state_r == B_DONE);

  assign bytes_eq = (pat_i[b_r] == pat_i[q_r - PAT_IDX_W'(1)]);

  // Prefix-function builder: one fallback or one table entry per cycle
  always_comb begin
    state_nxt = state_r;
    q_nxt     = q_r;
    b_nxt     = b_r;
    nb        = '0;
    wr_en     = 1'b0;
    unique case (state_r)
      B_BUILD: begin
        if ((b_r != '0) && !bytes_eq) begin
          b_nxt = f_rd;
        end else begin
          nb    = b_r + PAT_IDX_W'(bytes_eq);
          wr_en = 1'b1;
          b_nxt = nb;
          if (q_r == PAT_IDX_W'(PAT_BYTES - 1)) begin
            state_nxt = B_DONE;
          end else begin
            q_nxt = q_r + PAT_IDX_W'(1);
          end
        end
      end
      B_DONE: begin
      end
      default: begin
        state_nxt = B_BUILD;
      end
    endcase
    // A config write restarts the build
    if (start_i) begin
      state_nxt = B_BUILD;
      q_nxt     = PAT_IDX_W'(2);
      b_nxt     = '0;
      wr_en     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_BUILD;
      q_r     <= PAT_IDX_W'(2);
      b_r     <= '0;
    end else begin
      state_r <= state_nxt;
      q_r     <= q_nxt;
      b_r     <= b_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tab_r[q_r] <= nb;
    end
  end

endmodule

/* hw/rtl/bte_back.sv */
// Back end: border walk, release of held bytes and markers, output register.
module bte_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  bte_pkg::q_head_t               head_i,
  output logic                           pop_o,
  input  bte_pkg::pat_t                  pat_i,
  input  logic [bte_pkg::PLEN_W-1:0]     plen_i,
  input  logic                           tbl_ready_i,
  output logic [bte_pkg::PAT_IDX_W-1:0]  tbl_addr_o,
  input  logic [bte_pkg::PAT_IDX_W-1:0]  tbl_data_i,
  bte_out_if.source                      out_chan
);
  import bte_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_WALK = 4'b0010,
    S_EMIT = 4'b0100,
    S_MARK = 4'b1000
  } state_t;

  state_t               state_r, state_nxt;
  logic [PAT_IDX_W-1:0] match_len_r, match_len_nxt;
  logic                 finished_r, finished_nxt;
  logic [PAT_IDX_W-1:0] m_r, m_nxt;
  logic [7:0]           c_r, c_nxt;
  logic [PAT_IDX_W-1:0] k_r, k_nxt;
  logic [PLEN_W-1:0]    rel_r, rel_nxt;
  logic [PAT_IDX_W-1:0] i_r, i_nxt;
  kind_t                mark_r, mark_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [7:0]           out_byte_r;
  kind_t                out_kind_r;
  logic                 out_last_r;

  logic                 slot_free;
  logic                 load;
  logic [7:0]           ld_byte;
  kind_t                ld_kind;
  logic                 ld_last;

  logic [7:0]           pat_k;
  logic [PLEN_W-1:0]    k_ext;
  logic                 fall;
  logic                 hit;
  logic [PLEN_W-1:0]    k_fin;
  logic [PLEN_W-1:0]    rel_w;
  logic                 at_last;

  assign slot_free  = !out_valid_r || out_chan.ready;
  assign tbl_addr_o = k_r;

  // Walk step terms
  assign pat_k   = pat_i[k_r];
  assign k_ext   = {1'b0, k_r};
  assign fall    = (k_r != '0) && ((k_ext >= plen_i) || (pat_k != c_r));
  assign hit     = (k_ext < plen_i) && (pat_k == c_r);
  assign k_fin   = k_ext + PLEN_W'(hit);
  assign rel_w   = {1'b0, m_r} + PLEN_W'(1) - k_fin;
  assign at_last = ({1'b0, i_r} == rel_r - PLEN_W'(1));

  // Control sequence for one queued item
  always_comb begin
    state_nxt     = state_r;
    match_len_nxt = match_len_r;
    finished_nxt  = finished_r;
    m_nxt         = m_r;
    c_nxt         = c_r;
    k_nxt         = k_r;
    rel_nxt       = rel_r;
    i_nxt         = i_r;
    mark_nxt      = mark_r;
    pop_o         = 1'b0;
    load          = 1'b0;
    ld_byte       = 8'h00;
    ld_kind       = KIND_DATA;
    ld_last       = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (head_i.valid && (finished_r || tbl_ready_i)) begin
          pop_o = 1'b1;
          if (!finished_r) begin
            m_nxt = match_len_r;
            i_nxt = '0;
            if (head_i.item.eoi) begin
              // Flush held bytes, then the no-match marker
              rel_nxt       = {1'b0, match_len_r};
              mark_nxt      = KIND_NOMATCH;
              finished_nxt  = 1'b1;
              match_len_nxt = '0;
              state_nxt     = (match_len_r != '0) ? S_EMIT : S_MARK;
            end else begin
              c_nxt     = head_i.item.data;
              k_nxt     = match_len_r;
              state_nxt = S_WALK;
            end
          end
        end
      end
      S_WALK: begin
        if (fall) begin
          k_nxt = tbl_data_i;
        end else begin
          rel_nxt = rel_w;
          if (k_fin >= plen_i) begin
            mark_nxt      = KIND_FOUND;
            finished_nxt  = 1'b1;
            match_len_nxt = '0;
            state_nxt     = (rel_w != '0) ? S_EMIT : S_MARK;
          end else begin
            mark_nxt      = KIND_DATA;
            match_len_nxt = k_fin[PAT_IDX_W-1:0];
            state_nxt     = (rel_w != '0) ? S_EMIT : S_IDLE;
          end
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          load    = 1'b1;
          ld_byte = (i_r < m_r) ? pat_i[i_r] : c_r;
          ld_kind = KIND_DATA;
          ld_last = at_last && (mark_r == KIND_DATA);
          if (at_last) begin
            state_nxt = (mark_r != KIND_DATA) ? S_MARK : S_IDLE;
          end else begin
            i_nxt = i_r + PAT_IDX_W'(1);
          end
        end
      end
      S_MARK: begin
        if (slot_free) begin
          load      = 1'b1;
          ld_byte   = 8'h00;
          ld_kind   = mark_r;
          ld_last   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output register valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      match_len_r <= '0;
      finished_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      match_len_r <= match_len_nxt;
      finished_r  <= finished_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Per-item working registers and output payload
  always_ff @(posedge clk) begin
    m_r    <= m_nxt;
    c_r    <= c_nxt;
    k_r    <= k_nxt;
    rel_r  <= rel_nxt;
    i_r    <= i_nxt;
    mark_r <= mark_nxt;
    if (load) begin
      out_byte_r <= ld_byte;
      out_kind_r <= ld_kind;
      out_last_r <= ld_last;
    end
  end

  assign out_chan.valid    = out_valid_r;
  assign out_chan.out_byte = out_byte_r;
  assign out_chan.kind     = out_kind_r;
  assign out_chan.last     = out_last_r;

endmodule

/* hw/rtl/boundary_terminated_byte_extractor.sv */
// Top level of the boundary-terminated byte extractor: config registers and block wiring.
//
//  port      | dir  | moves
//  ----------+------+-----------------------------------------------------------
//  in_chan   | sink | item: in_byte, end_of_input (valid/ready)
//  out_chan  | src  | item: out_byte, kind, last (valid/ready)
//  cfg_*     | in   | register write: cfg_we, cfg_index, cfg_wdata (no read-back)
//
// An item leaves the queue, walks the border table one fallback step at a time in the match
// walk, and then emits its result items one by one.
// After reset and after every config write the border table is rebuilt; items are
// queued meanwhile but do not start until it is done.
// Input and output stall independently through a two-item queue and an output register.
// Reset is synchronous, active low; the table array itself is not reset.
module boundary_terminated_byte_extractor (
  input  logic                               clk,
  input  logic                               rst_n,
  bte_in_if.sink                             in_chan,
  bte_out_if.source                          out_chan,
  input  logic                               cfg_we,
  input  logic [bte_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bte_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import bte_pkg::*;

  logic [TOK_LEN_W-1:0]  token_len_r;
  logic [CFG_DATA_W-1:0] token_word0_r;
  logic [CFG_DATA_W-1:0] token_word1_r;
  logic [CFG_DATA_W-1:0] token_word2_r;
  logic [WORD3_W-1:0]    token_word3_r;

  logic [TOKEN_CAP*8-1:0] tok_bits;
  pat_t                   pat;
  logic [TOK_LEN_W-1:0]   tl;
  logic [PLEN_W-1:0]      plen;

  q_head_t              head;
  logic                 pop;
  logic                 tbl_ready;
  logic [PAT_IDX_W-1:0] tbl_addr;
  logic [PAT_IDX_W-1:0] tbl_data;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      token_len_r   <= TOK_LEN_W'(1);
      token_word0_r <= '0;
      token_word1_r <= '0;
      token_word2_r <= '0;
      token_word3_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TOKEN_LEN:   token_len_r   <= cfg_wdata[TOK_LEN_W-1:0];
        REG_TOKEN_WORD0: token_word0_r <= cfg_wdata;
        REG_TOKEN_WORD1: token_word1_r <= cfg_wdata;
        REG_TOKEN_WORD2: token_word2_r <= cfg_wdata;
        REG_TOKEN_WORD3: token_word3_r <= cfg_wdata[WORD3_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Delimiter pattern: fixed prefix, then all token bytes
  assign tok_bits = {token_word3_r, token_word2_r, token_word1_r, token_word0_r};

  always_comb begin
    pat[0] = CHAR_CR;
    pat[1] = CHAR_LF;
    pat[2] = CHAR_HYPHEN;
    pat[3] = CHAR_HYPHEN;
    for (int i = 0; i < TOKEN_CAP; i++) begin
      pat[PREFIX_BYTES + i] = tok_bits[i*8 +: 8];
    end
  end

  // Effective token length, clamped to its legal range
  always_comb begin
    if (token_len_r == '0) begin
      tl = TOK_LEN_W'(1);
    end else if (token_len_r > TOK_LEN_W'(TOK_LIM)) begin
      tl = TOK_LEN_W'(TOK_LIM);
    end else begin
      tl = token_len_r;
    end
  end

  assign plen = PLEN_W'(PREFIX_BYTES) + PLEN_W'(tl);

  bte_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .head_o  (head),
    .pop_i   (pop)
  );

  bte_border u_border (
    .clk       (clk),
    .rst_n     (rst_n),
    .start_i   (cfg_we),
    .pat_i     (pat),
    .rd_addr_i (tbl_addr),
    .rd_data_o (tbl_data),
    .ready_o   (tbl_ready)
  );

  bte_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head_i      (head),
    .pop_o       (pop),
    .pat_i       (pat),
    .plen_i      (plen),
    .tbl_ready_i (tbl_ready),
    .tbl_addr_o  (tbl_addr),
    .tbl_data_i  (tbl_data),
    .out_chan    (out_chan)
  );

endmodule

/* hw/rtl/bte_checker.sv */
// Port-level checker for the extractor, bound to the top level.
module bte_port_assert (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       in_eoi,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic [1:0] out_kind,
  input logic       out_last
);
  import bte_pkg::*;

  logic done_r, done_nxt;
  logic eoi_seen_r, eoi_seen_nxt;

  // Track a delivered marker and an accepted end of stream
  always_comb begin
    done_nxt     = done_r || (out_valid && out_ready && (out_kind != KIND_DATA));
    eoi_seen_nxt = eoi_seen_r || (in_valid && in_ready && in_eoi);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r     <= 1'b0;
      eoi_seen_r <= 1'b0;
    end else begin
      done_r     <= done_nxt;
      eoi_seen_r <= eoi_seen_nxt;
    end
  end

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_kind)
                                && $stable(out_last))
    else $error("stalled result changed");

  // Markers close the item and carry no byte
  a_marker_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind != KIND_DATA) |-> out_last && (out_byte == 8'h00))
    else $error("marker without last or with nonzero byte");

  // Nothing follows a delivered marker
  a_silent_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !out_valid)
    else $error("result after end of stream");

  // No-match marker only after an end-of-stream item
  a_nomatch_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_NOMATCH) |-> eoi_seen_r)
    else $error("no-match marker without end of stream");

endmodule

bind boundary_terminated_byte_extractor bte_port_assert u_bte_port_assert (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .in_eoi    (in_chan.end_of_input),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_byte  (out_chan.out_byte),
  .out_kind  (out_chan.kind),
  .out_last  (out_chan.last)
);

/* tb/sv/bte_checker.sv */
// Checker: watches both channels and the config port, predicts results and compares them.
module bte_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  bte_in_if                              in_mon,
  bte_out_if                             out_mon,
  input  logic                           cfg_we,
  input  logic [bte_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bte_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                             mismatches,
  output int                             expected_left
);
  timeunit 1ns;
  timeprecision 1ps;

  import bte_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    kind_t      kind;
    logic       last;
  } release_t;

  // Expected result items, oldest first
  release_t releases[$];

  // Shadow of the config registers and the matcher state
  logic [TOK_LEN_W-1:0] tok_len_r = TOK_LEN_W'(1);
  logic [63:0]          tok_word [4];
  logic [5:0]           held_r = '0;
  logic                 done_r = 1'b0;
  int                   fail_count = 0;

  // Delimiter length after clamping the token length
  function automatic int delim_len();
    int tl;
    tl = int'(tok_len_r);
    if (tl < 1) tl = 1;
    if (tl > TOKEN_CAP) tl = TOKEN_CAP;
    if (tl > MAX_DELIM_BYTES - PREFIX_BYTES) tl = MAX_DELIM_BYTES - PREFIX_BYTES;
    return PREFIX_BYTES + tl;
  endfunction

  // Fixed prefix followed by every token byte
  function automatic pat_t delim_pattern();
    pat_t p;
    p[0] = CHAR_CR;
    p[1] = CHAR_LF;
    p[2] = CHAR_HYPHEN;
    p[3] = CHAR_HYPHEN;
    for (int i = 0; i < TOKEN_CAP; i++)
      p[PREFIX_BYTES + i] = tok_word[i / 8][(i % 8) * 8 +: 8];
    return p;
  endfunction

  // Longest proper border of the first k pattern bytes
  function automatic int longest_border(input pat_t p, input int k);
    bit same;
    for (int b = k - 1; b > 0; b--) begin
      same = 1'b1;
      for (int j = 0; j < b; j++)
        if (p[j] != p[k - b + j]) same = 1'b0;
      if (same) return b;
    end
    return 0;
  endfunction

  task automatic push_release(input logic [7:0] d, input kind_t k, input logic lst);
    release_t r;
    r.data = d;
    r.kind = k;
    r.last = lst;
    releases.push_back(r);
  endtask

  // Advance the matcher by one body item and queue what it releases
  task automatic consume_body_item(input logic [7:0] c, input logic eoi);
    pat_t p;
    int   plen, m, k, n, rel;
    if (done_r) return;
    p    = delim_pattern();
    plen = delim_len();
    m    = int'(held_r);
    if (m > PAT_BYTES - 1) m = PAT_BYTES - 1;
    if (eoi) begin
      // flush held bytes, then the no-match marker
      for (int i = 0; i < m; i++) push_release(p[i], KIND_DATA, 1'b0);
      push_release(8'h00, KIND_NOMATCH, 1'b1);
      held_r = '0;
      done_r = 1'b1;
    end else begin
      // fall back along borders until c extends the match or nothing is held
      k = m;
      while (k > 0 && (k >= plen || p[k] != c)) k = longest_border(p, k);
      if (k < plen && p[k] == c) k++;
      rel = m + 1 - k;
      n   = rel + ((k >= plen) ? 1 : 0);
      for (int i = 0; i < rel; i++)
        push_release((i < m) ? p[i] : c, KIND_DATA, i == n - 1);
      if (k >= plen) begin
        push_release(8'h00, KIND_FOUND, 1'b1);
        held_r = '0;
        done_r = 1'b1;
      end else begin
        held_r = 6'(k);
      end
    end
  endtask

  task automatic check_release(input release_t got);
    release_t want;
    if (releases.size() == 0) begin
      fail_count++;
      $display("%0t: unexpected result: expected none, got data=%02h kind=%0d last=%0b",
               $time, got.data, got.kind, got.last);
    end else begin
      want = releases.pop_front();
      if (want.data !== got.data || want.kind !== got.kind || want.last !== got.last) begin
        fail_count++;
        $write("%0t: result mismatch: expected data=%02h kind=%0d last=%0b, ",
               $time, want.data, want.kind, want.last);
        $display("got data=%02h kind=%0d last=%0b", got.data, got.kind, got.last);
      end
    end
  endtask

  always @(posedge clk) begin : watch
    release_t got;
    if (!rst_n) begin
      tok_len_r = TOK_LEN_W'(1);
      tok_word  = '{default: '0};
      held_r    = '0;
      done_r    = 1'b0;
      releases.delete();
    end else begin
      // register writes take effect before any item of the same edge
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_TOKEN_LEN:   tok_len_r   = cfg_wdata[TOK_LEN_W-1:0];
          REG_TOKEN_WORD0: tok_word[0] = cfg_wdata;
          REG_TOKEN_WORD1: tok_word[1] = cfg_wdata;
          REG_TOKEN_WORD2: tok_word[2] = cfg_wdata;
          REG_TOKEN_WORD3: tok_word[3] = {32'h0, cfg_wdata[WORD3_W-1:0]};
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready)
        consume_body_item(in_mon.in_byte, in_mon.end_of_input);
      if (out_mon.valid && out_mon.ready) begin
        got.data = out_mon.out_byte;
        got.kind = kind_t'(out_mon.kind);
        got.last = out_mon.last;
        check_release(got);
      end
    end
    mismatches    <= fail_count;
    expected_left <= releases.size();
  end

endmodule

/* tb/sv/tb_top.sv */
// Testbench top: clock, reset, body stimulus, config phases, result sink and verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bte_pkg::*;

  localparam int BODY_PHASES    = 6;
  localparam int PHASE_ITEMS    = 44;
  localparam int SETTLE_CYCLES  = 100;
  localparam int RESULT_HOLDOFF = 300;
  localparam int HOLDOFF_AFTER  = 40;
  localparam int CYCLE_LIMIT    = 400000;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  int                    mismatches;
  int                    expected_left;
  int                    cycle_count = 0;
  int                    body_items = 0;
  bit                    in_quiet = 1'b0;
  bit                    out_quiet = 1'b0;

  // Token as last written, mirrored for building well-formed body sequences
  logic [7:0]            tok_bytes [TOKEN_CAP];
  logic [TOK_LEN_W-1:0]  tok_len_reg;

  bte_in_if  body_in ();
  bte_out_if body_out ();

  boundary_terminated_byte_extractor u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (body_in),
    .out_chan  (body_out),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  bte_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (body_in),
    .out_mon       (body_out),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .mismatches    (mismatches),
    .expected_left (expected_left)
  );

  // 12 ns clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic int token_span(input logic [TOK_LEN_W-1:0] len);
    int tl;
    tl = int'(len);
    if (tl < 1) tl = 1;
    if (tl > TOKEN_CAP) tl = TOKEN_CAP;
    return tl;
  endfunction

  function automatic int active_len();
    return PREFIX_BYTES + token_span(tok_len_reg);
  endfunction

  function automatic logic [7:0] delim_at(input int i);
    case (i)
      0:       return CHAR_CR;
      1:       return CHAR_LF;
      2, 3:    return CHAR_HYPHEN;
      default: return tok_bytes[i - PREFIX_BYTES];
    endcase
  endfunction

  // The closing byte is unique in the delimiter, so withholding it keeps the stream open
  function automatic logic [7:0] keep_open(input logic [7:0] b);
    return (b == delim_at(active_len() - 1)) ? (b ^ 8'h01) : b;
  endfunction

  task automatic send_item(input logic [7:0] b, input logic eoi);
    int gap;
    gap = in_quiet ? 0 : int'($urandom_range(3));
    if (gap > 0) begin
      body_in.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    body_in.valid        <= 1'b1;
    body_in.in_byte      <= b;
    body_in.end_of_input <= eoi;
    @(posedge clk);
    while (!body_in.ready) @(posedge clk);
  endtask

  task automatic send_body(input logic [7:0] b);
    send_item(keep_open(b), 1'b0);
    body_items++;
  endtask

  task automatic send_prefix(input int len);
    for (int i = 0; i < len; i++) send_body(delim_at(i));
  endtask

  task automatic cfg_write(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= d;
    @(posedge clk);
  endtask

  // Write all five registers; unused upper bits carry junk
  task automatic load_token(input logic [TOK_LEN_W-1:0] len);
    logic [63:0] words [4];
    logic [63:0] len_word;
    words = '{default: '0};
    words[3][63:32] = $urandom();
    for (int i = 0; i < TOKEN_CAP; i++) words[i / 8][(i % 8) * 8 +: 8] = tok_bytes[i];
    len_word = {$urandom(), $urandom()};
    len_word[TOK_LEN_W-1:0] = len;
    tok_len_reg = len;
    cfg_write(REG_TOKEN_LEN, len_word);
    cfg_write(REG_TOKEN_WORD0, words[0]);
    cfg_write(REG_TOKEN_WORD1, words[1]);
    cfg_write(REG_TOKEN_WORD2, words[2]);
    cfg_write(REG_TOKEN_WORD3, words[3]);
    cfg_we <= 1'b0;
  endtask

  // Token bytes biased toward prefix characters so borders and overlaps show up
  task automatic fill_token(input int tl);
    int pos;
    for (int i = 0; i < TOKEN_CAP; i++) begin
      case ($urandom_range(5))
        0:       tok_bytes[i] = CHAR_CR;
        1:       tok_bytes[i] = CHAR_LF;
        2:       tok_bytes[i] = CHAR_HYPHEN;
        3:       tok_bytes[i] = 8'h61;
        default: tok_bytes[i] = 8'($urandom_range(255));
      endcase
    end
    if (tl >= 5 && $urandom_range(1) == 1) begin
      pos = int'($urandom_range(0, tl - 5));
      tok_bytes[pos]     = CHAR_CR;
      tok_bytes[pos + 1] = CHAR_LF;
      tok_bytes[pos + 2] = CHAR_HYPHEN;
      tok_bytes[pos + 3] = CHAR_HYPHEN;
    end
  endtask

  // Closing token byte: not a prefix character and nowhere else in the token
  task automatic seal_token(input int tl);
    logic [7:0] b;
    bit         clash;
    do begin
      b = 8'($urandom_range(255));
      clash = (b == CHAR_CR || b == CHAR_LF || b == CHAR_HYPHEN);
      for (int i = 0; i < tl - 1; i++)
        if (tok_bytes[i] == b) clash = 1'b1;
    end while (clash);
    tok_bytes[tl - 1] = b;
  endtask

  // Wait until every predicted result is out and any silent item is done
  task automatic drain_results();
    body_in.valid <= 1'b0;
    @(posedge clk);
    while (expected_left != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Run limit
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // Result sink: random stalls, quiet stretches, and one long hold-off
  initial begin : result_sink
    int taken;
    int stall;
    taken = 0;
    body_out.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (taken % 32 == 0) out_quiet = ($urandom_range(3) == 0);
      stall = out_quiet ? 0 : int'($urandom_range(3));
      if (taken == HOLDOFF_AFTER) stall = RESULT_HOLDOFF;
      if (stall > 0) begin
        body_out.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      body_out.ready <= 1'b1;
      @(posedge clk);
      while (!body_out.valid) @(posedge clk);
      taken++;
    end
  end

  // Stimulus
  initial begin : stimulus
    logic [7:0]           opening [10];
    logic [7:0]           second [6];
    logic [TOK_LEN_W-1:0] len_sel;
    int                   phase_mark;
    int unsigned          pick;
    opening = '{8'hFF, CHAR_CR, CHAR_CR, CHAR_LF, CHAR_HYPHEN, CHAR_HYPHEN, 8'hFF,
                CHAR_CR, CHAR_LF, CHAR_HYPHEN};
    second  = '{CHAR_HYPHEN, 8'h00, CHAR_CR, CHAR_LF, CHAR_HYPHEN, CHAR_HYPHEN};
    foreach (tok_bytes[i]) tok_bytes[i] = 8'h00;
    tok_len_reg = TOK_LEN_W'(1);

    rst_n                <= 1'b0;
    cfg_we               <= 1'b0;
    cfg_index            <= REG_TOKEN_LEN;
    cfg_wdata            <= '0;
    body_in.valid        <= 1'b0;
    body_in.in_byte      <= 8'h00;
    body_in.end_of_input <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Reset token: CR CR fallback, a broken full prefix, then three bytes held
    foreach (opening[i]) send_body(opening[i]);

    // Token length 0 acts as 1; word extremes; held bytes carried across the write
    drain_results();
    for (int i = 0; i < TOKEN_CAP; i++) begin
      if (i == 0)       tok_bytes[i] = 8'h51;
      else if (i < 8)   tok_bytes[i] = 8'($urandom());
      else if (i < 16)  tok_bytes[i] = 8'hFF;
      else if (i < 24)  tok_bytes[i] = 8'h00;
      else              tok_bytes[i] = 8'hFF;
    end
    load_token(TOK_LEN_W'(0));
    foreach (second[i]) send_body(second[i]);

    // Oversized length clamps to the full token; hold nine bytes of a self-overlapping token
    drain_results();
    fill_token(TOKEN_CAP);
    tok_bytes[0] = 8'h61;
    tok_bytes[1] = CHAR_CR;
    tok_bytes[2] = CHAR_LF;
    tok_bytes[3] = CHAR_HYPHEN;
    tok_bytes[4] = CHAR_HYPHEN;
    seal_token(TOKEN_CAP);
    load_token(TOK_LEN_W'(31));
    for (int i = PREFIX_BYTES; i < PREFIX_BYTES + 5; i++) send_body(delim_at(i));

    // Random phases; the first shrinks the delimiter below the held count
    for (int ph = 0; ph < BODY_PHASES; ph++) begin
      drain_results();
      if (ph == 0) begin
        len_sel = TOK_LEN_W'(1);
      end else begin
        case ($urandom_range(7))
          0:       len_sel = TOK_LEN_W'(0);
          1:       len_sel = TOK_LEN_W'(28);
          2:       len_sel = TOK_LEN_W'($urandom_range(29, 31));
          3:       len_sel = TOK_LEN_W'(1);
          default: len_sel = TOK_LEN_W'($urandom_range(2, 10));
        endcase
      end
      fill_token(token_span(len_sel));
      seal_token(token_span(len_sel));
      load_token(len_sel);
      in_quiet = ($urandom_range(3) == 0);
      phase_mark = body_items;
      while (body_items - phase_mark < PHASE_ITEMS) begin
        pick = $urandom_range(9);
        if (pick < 6) begin
          // partial delimiter, sometimes broken by a random byte
          send_prefix(int'($urandom_range(1, active_len() - 1)));
          if ($urandom_range(1) == 1) send_body(8'($urandom_range(255)));
        end else if (pick < 8) begin
          repeat ($urandom_range(1, 4)) send_body(8'($urandom_range(255)));
        end else begin
          case ($urandom_range(2))
            0:       send_body(CHAR_CR);
            1:       send_body(CHAR_LF);
            default: send_body(CHAR_HYPHEN);
          endcase
        end
      end
    end

    // Close the stream: full delimiter, or end of input after a possibly empty partial delimiter
    if ($urandom_range(1) == 1) begin
      for (int i = 0; i < active_len(); i++) send_item(delim_at(i), 1'b0);
    end else begin
      send_prefix(int'($urandom_range(0, active_len() - 1)));
      send_item(8'($urandom_range(255)), 1'b1);
    end

    // Items after the stream has ended must give nothing
    send_item(8'($urandom_range(255)), 1'b0);
    send_item(8'($urandom_range(255)), 1'b1);
    send_item(8'($urandom_range(255)), 1'b0);

    drain_results();
    if (mismatches == 0 && expected_left == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
